// ----- rtl/arrm_pkg.sv -----
`default_nettype none
package arrm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } arrm_action_t;

  typedef enum logic [2:0] {
    ST_INSERTED     = 3'd0,
    ST_HIT          = 3'd1,
    ST_OUT_OF_RANGE = 3'd2,
    ST_NO_MATCH     = 3'd3,
    ST_FULL         = 3'd4
  } arrm_status_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_BUSY
  } arrm_ctl_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] region_start;
    logic [63:0] region_size;
    logic [7:0]  target_x;
    logic [7:0]  target_y;
    logic [63:0] lookup_address;
  } arrm_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  hit_x;
    logic [7:0]  hit_y;
    logic [63:0] placed_start;
  } arrm_rsp_t;

  // token passed along the cell row
  typedef struct packed {
    logic             valid;
    logic             write;
    logic [CNT_W-1:0] remaining;
    logic [63:0]      addr;
    logic [63:0]      size;
    logic [7:0]       x;
    logic [7:0]       y;
    logic             hit;
  } arrm_probe_t;

endpackage
`default_nettype wire

// ----- rtl/arrm_cell.sv -----
`default_nettype none
module arrm_cell
  import arrm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire arrm_probe_t probe_in,
  output arrm_probe_t      probe_out
);

  logic [63:0] entry_start;
  logic [63:0] entry_size;
  logic [7:0]  entry_x;
  logic [7:0]  entry_y;

  arrm_probe_t probe_next;
  logic        occupied;
  logic        do_write;
  logic        match;
  logic [63:0] offset;

  always_comb begin
    occupied = (probe_in.remaining != '0);
    do_write = probe_in.valid && probe_in.write && !occupied && !probe_in.hit;
    offset   = probe_in.addr - entry_start;
    match    = probe_in.valid && !probe_in.write && occupied && (offset < entry_size);

    probe_next = probe_in;
    if (occupied) begin
      probe_next.remaining = probe_in.remaining - CNT_W'(1);
    end
    if (do_write) begin
      probe_next.hit = 1'b1;
    end
    if (match) begin
      probe_next.hit = 1'b1;
      probe_next.x   = entry_x;
      probe_next.y   = entry_y;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      entry_start <= probe_in.addr;
      entry_size  <= probe_in.size;
      entry_x     <= probe_in.x;
      entry_y     <= probe_in.y;
    end
  end

  always_ff @(posedge clk) begin
    probe_out <= probe_next;
    if (rst) begin
      probe_out.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/address_region_router_map.sv -----
// an immediate result (a full-table refusal, an out-of-range lookup or the unused action)
// goes straight to the output register; any other item walks the row of entry cells first
// one item at a time: no new request is taken while an item is in the row of entry cells
// reset: synchronous, clears the region count, the top address and all control state;
// stored entries are only read below the count and need no clearing
`default_nettype none
module address_region_router_map
  import arrm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire arrm_req_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output arrm_rsp_t      rsp
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  arrm_ctl_state_t state;
  arrm_ctl_state_t state_next;

  logic [CNT_W-1:0] entry_count;
  logic [63:0]      top_address;

  arrm_probe_t chain [TABLE_DEPTH+1];

  logic        accept;
  logic        immediate;
  logic        is_place;
  logic        full;
  logic [63:0] place_start;
  logic [63:0] place_end;
  arrm_rsp_t   imm_rsp;
  arrm_rsp_t   chain_rsp;
  arrm_probe_t launch;

  assign req_stall = (state == CTL_BUSY) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    is_place    = (req.action == ACT_INSERT) || (req.action == ACT_APPEND);
    full        = (entry_count == DEPTH_CNT);
    place_start = (req.action == ACT_INSERT) ? req.region_start : top_address;
    place_end   = place_start + req.region_size;
    imm_rsp     = '0;
    immediate   = 1'b0;
    unique case (req.action) inside
      ACT_INSERT, ACT_APPEND: begin
        if (full) begin
          immediate      = 1'b1;
          imm_rsp.status = ST_FULL;
        end
      end
      ACT_LOOKUP: begin
        if (req.lookup_address >= top_address) begin
          immediate      = 1'b1;
          imm_rsp.status = ST_OUT_OF_RANGE;
        end
      end
      default: begin
        immediate      = 1'b1;
        imm_rsp.status = ST_NO_MATCH;
      end
    endcase

    launch           = '0;
    launch.valid     = accept && !immediate;
    launch.write     = is_place;
    launch.remaining = entry_count;
    launch.addr      = is_place ? place_start : req.lookup_address;
    launch.size      = req.region_size;
    launch.x         = is_place ? req.target_x : 8'd0;
    launch.y         = is_place ? req.target_y : 8'd0;
  end

  assign chain[0] = launch;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    arrm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1])
    );
  end

  always_comb begin
    chain_rsp = '0;
    if (chain[TABLE_DEPTH].write) begin
      chain_rsp.status       = ST_INSERTED;
      chain_rsp.placed_start = chain[TABLE_DEPTH].addr;
    end else if (chain[TABLE_DEPTH].hit) begin
      chain_rsp.status = ST_HIT;
      chain_rsp.hit_x  = chain[TABLE_DEPTH].x;
      chain_rsp.hit_y  = chain[TABLE_DEPTH].y;
    end else begin
      chain_rsp.status = ST_NO_MATCH;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CTL_IDLE: begin
        if (launch.valid) begin
          state_next = CTL_BUSY;
        end
      end
      CTL_BUSY: begin
        if (chain[TABLE_DEPTH].valid) begin
          state_next = CTL_IDLE;
        end
      end
      default: state_next = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // region count and top address
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      top_address <= '0;
    end else if (accept && is_place && !full) begin
      entry_count <= entry_count + CNT_W'(1);
      if (place_end > top_address) begin
        top_address <= place_end;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && immediate) begin
      rsp_valid <= 1'b1;
    end else if (chain[TABLE_DEPTH].valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && immediate) begin
      rsp <= imm_rsp;
    end else if (chain[TABLE_DEPTH].valid) begin
      rsp <= chain_rsp;
    end
  end

endmodule
`default_nettype wire

// ----- tb/address_region_router_map_tb.sv -----
module address_region_router_map_tb;
  import arrm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  arrm_req_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  arrm_rsp_t rsp;

  // predicted map contents
  logic [63:0] map_start [TABLE_DEPTH];
  logic [63:0] map_size [TABLE_DEPTH];
  logic [7:0]  map_x [TABLE_DEPTH];
  logic [7:0]  map_y [TABLE_DEPTH];
  int          map_count = 0;
  logic [63:0] map_top = '0;

  arrm_rsp_t routes_expected [$];
  arrm_rsp_t next_route;

  int  mismatches = 0;
  int  items_sent = 0;
  int  status_seen [8];
  int  cycle_count = 0;
  bit  feed_idle = 1'b1;
  bit  drain_idle = 1'b1;
  int  drain_wait = 0;
  int  drain_pick = 0;
  int  hold_cycles = 0;

  address_region_router_map uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // updates the predicted map and returns the answer to one request
  function automatic arrm_rsp_t route_request(input arrm_req_t item);
    arrm_rsp_t   res;
    logic [63:0] base;
    logic [63:0] stop;
    int          idx;
    res = '0;
    case (item.action) inside
      ACT_INSERT, ACT_APPEND: begin
        base = (item.action == ACT_APPEND) ? map_top : item.region_start;
        if (map_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          map_start[map_count] = base;
          map_size[map_count] = item.region_size;
          map_x[map_count] = item.target_x;
          map_y[map_count] = item.target_y;
          map_count++;
          stop = base + item.region_size;
          if (stop > map_top) map_top = stop;
          res.status = ST_INSERTED;
          res.placed_start = base;
        end
      end
      ACT_LOOKUP: begin
        if (item.lookup_address >= map_top) begin
          res.status = ST_OUT_OF_RANGE;
        end else begin
          res.status = ST_NO_MATCH;
          // newest region wins
          for (idx = map_count - 1; idx >= 0 && res.status != ST_HIT; idx--) begin
            if (item.lookup_address - map_start[idx] < map_size[idx]) begin
              res.status = ST_HIT;
              res.hit_x = map_x[idx];
              res.hit_y = map_y[idx];
            end
          end
        end
      end
      default: res.status = ST_NO_MATCH;
    endcase
    return res;
  endfunction

  function automatic arrm_req_t make_req(input arrm_action_t act, input logic [63:0] start,
                                         input logic [63:0] size, input logic [7:0] x,
                                         input logic [7:0] y, input logic [63:0] addr);
    arrm_req_t item;
    item.action = act;
    item.region_start = start;
    item.region_size = size;
    item.target_x = x;
    item.target_y = y;
    item.lookup_address = addr;
    return item;
  endfunction

  // lookup addresses: random, or aimed at regions, their edges and the top
  function automatic logic [63:0] pick_address();
    int sel;
    int idx;
    sel = $urandom_range(0, 99);
    if (map_count == 0 || sel < 20) return rand64();
    idx = $urandom_range(0, map_count - 1);
    if (sel < 60) begin
      if (map_size[idx] == 0) return map_start[idx];
      return map_start[idx] + rand64() % map_size[idx];
    end
    if (sel < 70) return map_start[idx] - 1;
    if (sel < 80) return map_start[idx] + map_size[idx];
    if (sel < 90) return map_top - $urandom_range(0, 3);
    return map_top + $urandom_range(0, 3);
  endfunction

  task automatic send_item(input arrm_req_t item);
    int gap;
    gap = feed_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    routes_expected.push_back(route_request(item));
    items_sent++;
  endtask

  task automatic place_region(input arrm_action_t act, input logic [63:0] start,
                              input logic [63:0] size, input logic [7:0] x,
                              input logic [7:0] y);
    send_item(make_req(act, start, size, x, y, rand64()));
  endtask

  task automatic route_address(input logic [63:0] addr);
    send_item(make_req(ACT_LOOKUP, rand64(), rand64(), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), addr));
  endtask

  task automatic send_noise(input arrm_action_t act);
    send_item(make_req(act, rand64(), rand64(), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), rand64()));
  endtask

  task automatic test_empty_table();
    route_address(64'd0);
    route_address({64{1'b1}});
    send_item(make_req(ACT_NONE, {64{1'b1}}, {64{1'b1}}, 8'hff, 8'hff, {64{1'b1}}));
  endtask

  task automatic test_region_layout();
    place_region(ACT_APPEND, rand64(), 64'h1000, 8'hff, 8'h00);
    place_region(ACT_INSERT, 64'h1800, 64'h800, 8'h00, 8'hff);
    route_address(64'h17ff);
    route_address(64'h0);
    route_address(64'h1fff);
    route_address(64'h2000);
    // newer overlapping region takes priority
    place_region(ACT_INSERT, 64'h1c00, 64'h10, 8'h5a, 8'ha5);
    route_address(64'h1c08);
    place_region(ACT_INSERT, 64'h100, 64'h0, 8'h11, 8'h22);
    route_address(64'h100);
    // end wraps past zero and leaves the top alone
    place_region(ACT_INSERT, {64{1'b1}}, 64'h2, 8'h01, 8'h02);
    route_address(64'h0);
    place_region(ACT_INSERT, 64'h1001, {64{1'b1}}, 8'h3c, 8'hc3);
    route_address(64'h1000);
    route_address(64'h1234);
    place_region(ACT_APPEND, 64'h0, 64'h10, 8'h80, 8'h7f);
    route_address(64'h2008);
    route_address({64{1'b1}});
  endtask

  task automatic test_random_fill();
    int          sel;
    logic [63:0] start;
    logic [63:0] size;
    while (map_count < TABLE_DEPTH) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        start = ($urandom_range(0, 3) == 0) ? rand64() : (rand64() & 64'hff_ffff);
        size = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(1, 65535));
        place_region(arrm_action_t'(($urandom_range(0, 1) == 0) ? ACT_INSERT : ACT_APPEND),
                     start, size, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (sel < 95) begin
        route_address(pick_address());
      end else begin
        send_noise(ACT_NONE);
      end
    end
  endtask

  task automatic test_table_full();
    place_region(ACT_INSERT, {64{1'b1}}, {64{1'b1}}, 8'hff, 8'hff);
    place_region(ACT_APPEND, 64'h0, 64'h0, 8'h00, 8'h00);
    route_address(map_top - 1);
    route_address(map_top);
  endtask

  task automatic test_random_routes();
    int n;
    int sel;
    for (n = 0; n < 1150; n++) begin
      if (n % 100 == 0) begin
        feed_idle = (n == 100) ? 1'b0 : ($urandom_range(0, 2) != 0);
        drain_idle = (n == 100) ? 1'b0 : ($urandom_range(0, 2) != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 75) route_address(pick_address());
      else if (sel < 85) send_noise(ACT_INSERT);
      else if (sel < 93) send_noise(ACT_APPEND);
      else send_noise(ACT_NONE);
    end
    feed_idle = 1'b1;
    drain_idle = 1'b1;
  endtask

  task automatic test_hold_off();
    int n;
    feed_idle = 1'b0;
    hold_cycles = 300;
    for (n = 0; n < 40; n++) route_address(pick_address());
    feed_idle = 1'b1;
  endtask

  // result side: random pauses after each transfer, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (drain_wait > 0) begin
      rsp_stall <= 1'b1;
      drain_wait <= drain_wait - 1;
    end else if (rsp_valid && !rsp_stall) begin
      drain_pick = drain_idle ? $urandom_range(0, 9) : 0;
      rsp_stall <= (drain_pick != 0);
      drain_wait <= (drain_pick > 1) ? drain_pick - 1 : 0;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (routes_expected.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status %0d x %h y %h start %h",
                   rsp.status, rsp.hit_x, rsp.hit_y, rsp.placed_start);
        mismatches++;
      end else begin
        next_route = routes_expected.pop_front();
        status_seen[next_route.status]++;
        if (rsp.status !== next_route.status || rsp.hit_x !== next_route.hit_x ||
            rsp.hit_y !== next_route.hit_y || rsp.placed_start !== next_route.placed_start)
        begin
          if (mismatches < 10)
            $display("mismatch: expected status %0d x %h y %h start %h, got %0d %h %h %h",
                     next_route.status, next_route.hit_x, next_route.hit_y,
                     next_route.placed_start, rsp.status, rsp.hit_x, rsp.hit_y,
                     rsp.placed_start);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               routes_expected.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_region_layout();
    test_random_fill();
    test_table_full();
    test_random_routes();
    test_hold_off();
    req_valid <= 1'b0;
    while (routes_expected.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    $display("%0d requests over %0d cycles, %0d mismatches", items_sent, cycle_count,
             mismatches);
    $display("placed %0d, hit %0d, out of range %0d, no match %0d, refused full %0d",
             status_seen[ST_INSERTED], status_seen[ST_HIT], status_seen[ST_OUT_OF_RANGE],
             status_seen[ST_NO_MATCH], status_seen[ST_FULL]);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
